FILE: hw/rtl/ustar_pkg.sv
// Shared types, header layout constants and small helper functions for the
// ustar stream deframer. No dependencies; used by the deframer and its checker.
package ustar_pkg;

    // Stream widths.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SIZE_W  = 36;
    localparam int unsigned POS_W   = 9;
    localparam int unsigned FLAG_W  = 5;
    localparam int unsigned TDATA_W = 56;
    localparam int unsigned TUSER_W = 2;

    // Result word field positions inside m_tdata, lowest bit first.
    localparam int unsigned F_VALUE_LO = 0;
    localparam int unsigned F_HC_BIT   = 8;
    localparam int unsigned F_KIND_LO  = 9;
    localparam int unsigned F_SIZE_LO  = 11;
    localparam int unsigned F_STAT_LO  = 47;
    localparam int unsigned F_USED_W   = 49;

    // Header block layout.
    localparam logic [POS_W-1:0] LAST_POS   = 9'd511;
    localparam logic [POS_W-1:0] NAME_END   = 9'd100;
    localparam logic [POS_W-1:0] SIZE_OFF   = 9'd124;
    localparam logic [POS_W-1:0] SIZE_END   = 9'd136;
    localparam logic [POS_W-1:0] TYPE_OFF   = 9'd156;
    localparam logic [POS_W-1:0] PREFIX_OFF = 9'd345;
    localparam logic [POS_W-1:0] PREFIX_END = 9'd500;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_DIR   = 8'h35;
    localparam logic [BYTE_W-1:0] CH_LINK  = 8'h32;

    // Path tracker flag bits.
    localparam int unsigned PF_NZ      = 0;
    localparam int unsigned PF_SLASH   = 1;
    localparam int unsigned PF_DD      = 2;
    localparam int unsigned PF_PREVDOT = 3;
    localparam int unsigned PF_ENDED   = 4;

    // Byte classes (m_tuser).
    localparam logic [1:0] BC_HEADER  = 2'd0;
    localparam logic [1:0] BC_PAYLOAD = 2'd1;
    localparam logic [1:0] BC_PAD     = 2'd2;
    localparam logic [1:0] BC_IGNORED = 2'd3;

    // Entry kinds.
    localparam logic [1:0] KIND_REGULAR = 2'd0;
    localparam logic [1:0] KIND_DIR     = 2'd1;
    localparam logic [1:0] KIND_LINK    = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_END       = 2'd1;
    localparam logic [1:0] ST_UNSAFE    = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_PAD,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        SZ_SKIP,
        SZ_DIGITS,
        SZ_DONE
    } size_stage_t;

    // Update the path flags of one path part with the next byte.
    function automatic logic [FLAG_W-1:0] track_path(input logic [FLAG_W-1:0] f,
                                                    input logic              first,
                                                    input logic [BYTE_W-1:0] b);
        logic [FLAG_W-1:0] r;
        r = f;
        if (f[PF_ENDED]) begin
            r = f;
        end else if (b == '0) begin
            r[PF_ENDED] = 1'b1;
        end else begin
            if (first) begin
                r[PF_NZ] = 1'b1;
                if (b == CH_SLASH) begin
                    r[PF_SLASH] = 1'b1;
                end
            end
            if (b == CH_DOT) begin
                if (f[PF_PREVDOT]) begin
                    r[PF_DD] = 1'b1;
                end
                r[PF_PREVDOT] = 1'b1;
            end else begin
                r[PF_PREVDOT] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [1:0] kind_of(input logic [BYTE_W-1:0] t);
        logic [1:0] k;
        if (t == CH_DIR) begin
            k = KIND_DIR;
        end else if (t == CH_LINK) begin
            k = KIND_LINK;
        end else begin
            k = KIND_REGULAR;
        end
        return k;
    endfunction

    function automatic logic path_unsafe(input logic [FLAG_W-1:0] pre,
                                         input logic [FLAG_W-1:0] nam);
        logic u;
        if (pre[PF_NZ]) begin
            u = pre[PF_SLASH] | pre[PF_DD] | nam[PF_DD];
        end else begin
            u = !nam[PF_NZ] | nam[PF_SLASH] | nam[PF_DD];
        end
        return u;
    endfunction

endpackage

FILE: hw/rtl/ustar_stream_deframer_unit.sv
// Streaming ustar archive deframer: classes each archive byte and checks headers.
// Depends on ustar_pkg for layout constants, enums and path helper functions.
//
// Channel  | Dir | Word contents
// ---------+-----+----------------------------------------------------------------
// s_       | in  | tdata: archive_byte; tlast: final_byte
// m_       | out | tdata: byte_value, header_complete, entry_kind, entry_size,
//          |     |        status; tuser: byte_class
//
// One word is accepted per cycle while s_tready is high, and its result appears in the
// output register on the next cycle. All header checks run incrementally on the byte in
// flight against the parser registers. aresetn is synchronous and active low; it empties
// the output register and returns the parser to the start of a header block. When
// m_tready is low with a result held, s_tready drops and the parser holds its state.
module ustar_stream_deframer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: [7:0] archive_byte
    input  logic [ustar_pkg::BYTE_W-1:0]   s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: [7:0] byte_value, [8] header_complete, [10:9] entry_kind,
    //        [46:11] entry_size, [48:47] status, [55:49] zero
    output logic [ustar_pkg::TDATA_W-1:0]  m_tdata,
    // tuser: [1:0] byte_class
    output logic [ustar_pkg::TUSER_W-1:0]  m_tuser
);
    import ustar_pkg::*;

    // Parser state.
    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SIZE_W-1:0]   payload_left_reg, payload_left_next;
    logic [POS_W-1:0]    pad_left_reg, pad_left_next;
    logic                all_zero_reg, all_zero_next;
    logic [SIZE_W-1:0]   size_acc_reg, size_acc_next;
    size_stage_t         stage_reg, stage_next;
    logic [BYTE_W-1:0]   type_reg, type_next;
    logic [FLAG_W-1:0]   name_flags_reg, name_flags_next;
    logic [FLAG_W-1:0]   prefix_flags_reg, prefix_flags_next;

    // Output register.
    logic                m_tvalid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic                s_fire;
    logic                begin_hdr;
    logic                is_octal;
    logic [1:0]          res_class;
    logic                res_hc;
    logic [1:0]          res_kind;
    logic [1:0]          res_status;
    logic [SIZE_W-1:0]   res_size;
    logic [1:0]          cur_kind;

    // The output register frees up in the same cycle its word is taken.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign is_octal = (s_tdata[7:3] == 5'b00110);
    assign cur_kind = kind_of(type_reg);

    always_comb begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        payload_left_next = payload_left_reg;
        pad_left_next     = pad_left_reg;
        all_zero_next     = all_zero_reg;
        size_acc_next     = size_acc_reg;
        stage_next        = stage_reg;
        type_next         = type_reg;
        name_flags_next   = name_flags_reg;
        prefix_flags_next = prefix_flags_reg;
        begin_hdr         = 1'b0;
        res_class         = BC_IGNORED;
        res_hc            = 1'b0;
        res_kind          = KIND_REGULAR;
        res_status        = ST_OK;
        res_size          = '0;

        if (s_fire) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    res_class = BC_HEADER;
                    if (s_tdata != '0) begin
                        all_zero_next = 1'b0;
                    end
                    if (pos_reg < NAME_END) begin
                        name_flags_next = track_path(name_flags_reg, pos_reg == '0, s_tdata);
                    end
                    if (pos_reg >= PREFIX_OFF && pos_reg < PREFIX_END) begin
                        prefix_flags_next = track_path(prefix_flags_reg,
                                                       pos_reg == PREFIX_OFF, s_tdata);
                    end
                    // Octal size field: skip leading spaces, then take digits until
                    // the first byte that is not an octal digit.
                    if (pos_reg >= SIZE_OFF && pos_reg < SIZE_END) begin
                        case (stage_reg)
                            SZ_SKIP: begin
                                if (s_tdata == CH_SPACE) begin
                                    stage_next = SZ_SKIP;
                                end else if (is_octal) begin
                                    size_acc_next = {{(SIZE_W-3){1'b0}}, s_tdata[2:0]};
                                    stage_next    = SZ_DIGITS;
                                end else begin
                                    stage_next = SZ_DONE;
                                end
                            end
                            SZ_DIGITS: begin
                                if (is_octal) begin
                                    size_acc_next = {size_acc_reg[SIZE_W-4:0], s_tdata[2:0]};
                                end else begin
                                    stage_next = SZ_DONE;
                                end
                            end
                            default: begin
                                stage_next = stage_reg;
                            end
                        endcase
                    end
                    if (pos_reg == TYPE_OFF) begin
                        type_next = s_tdata;
                    end

                    if (pos_reg == LAST_POS) begin
                        if (all_zero_next) begin
                            res_status = ST_END;
                            phase_next = PH_STOP;
                        end else if (path_unsafe(prefix_flags_next, name_flags_next)) begin
                            res_status = ST_UNSAFE;
                            phase_next = PH_STOP;
                        end else begin
                            res_hc   = 1'b1;
                            res_kind = kind_of(type_next);
                            res_size = size_acc_next;
                            if (size_acc_next == '0) begin
                                begin_hdr = 1'b1;
                            end else begin
                                payload_left_next = size_acc_next;
                                // Padding to the next block boundary, zero when aligned.
                                pad_left_next = ~size_acc_next[POS_W-1:0] + 9'd1;
                                phase_next    = PH_PAYLOAD;
                                if (s_tlast && res_kind == KIND_REGULAR) begin
                                    res_status = ST_TRUNCATED;
                                end
                            end
                        end
                    end else begin
                        pos_next = pos_reg + 9'd1;
                    end
                end
                PH_PAYLOAD: begin
                    res_class = BC_PAYLOAD;
                    res_kind  = cur_kind;
                    res_size  = size_acc_reg;
                    if (payload_left_reg != '0) begin
                        payload_left_next = payload_left_reg - 36'd1;
                    end
                    if (payload_left_next == '0) begin
                        if (pad_left_reg != '0) begin
                            phase_next = PH_PAD;
                        end else begin
                            begin_hdr = 1'b1;
                        end
                    end else if (s_tlast && cur_kind == KIND_REGULAR) begin
                        res_status = ST_TRUNCATED;
                    end
                end
                PH_PAD: begin
                    res_class = BC_PAD;
                    res_kind  = cur_kind;
                    res_size  = size_acc_reg;
                    if (pad_left_reg != '0) begin
                        pad_left_next = pad_left_reg - 9'd1;
                    end
                    if (pad_left_next == '0) begin
                        begin_hdr = 1'b1;
                    end
                end
                PH_STOP: begin
                    res_class = BC_IGNORED;
                end
                default: begin
                    res_class = BC_IGNORED;
                end
            endcase

            // Start of a new header block, or of a new archive after the last word.
            if (begin_hdr || s_tlast) begin
                phase_next        = PH_HEADER;
                pos_next          = '0;
                all_zero_next     = 1'b1;
                size_acc_next     = '0;
                stage_next        = SZ_SKIP;
                type_next         = '0;
                name_flags_next   = '0;
                prefix_flags_next = '0;
            end
            if (s_tlast) begin
                payload_left_next = '0;
                pad_left_next     = '0;
            end
        end

        m_tdata_next = {{(TDATA_W-F_USED_W){1'b0}}, res_status, res_size, res_kind,
                        res_hc, s_tdata};
        m_tuser_next = res_class;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            pos_reg          <= '0;
            payload_left_reg <= '0;
            pad_left_reg     <= '0;
            all_zero_reg     <= 1'b1;
            size_acc_reg     <= '0;
            stage_reg        <= SZ_SKIP;
            type_reg         <= '0;
            name_flags_reg   <= '0;
            prefix_flags_reg <= '0;
        end else begin
            phase_reg        <= phase_next;
            pos_reg          <= pos_next;
            payload_left_reg <= payload_left_next;
            pad_left_reg     <= pad_left_next;
            all_zero_reg     <= all_zero_next;
            size_acc_reg     <= size_acc_next;
            stage_reg        <= stage_next;
            type_reg         <= type_next;
            name_flags_reg   <= name_flags_next;
            prefix_flags_reg <= prefix_flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: hw/rtl/ustar_checker.sv
// Port-level checks for the ustar stream deframer, bound to its top level.
// Depends on ustar_pkg for result word field positions and codes.
module ustar_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [ustar_pkg::BYTE_W-1:0]  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ustar_pkg::TDATA_W-1:0] m_tdata,
    input logic [ustar_pkg::TUSER_W-1:0] m_tuser
);
    import ustar_pkg::*;

    logic              hc;
    logic [1:0]        kind;
    logic [1:0]        stat;
    logic [SIZE_W-1:0] size;

    assign hc   = m_tdata[F_HC_BIT];
    assign kind = m_tdata[F_KIND_LO +: 2];
    assign stat = m_tdata[F_STAT_LO +: 2];
    assign size = m_tdata[F_SIZE_LO +: SIZE_W];

    // A stalled result word holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // An accepted input word shows up as a result on the next cycle with its byte.
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid && m_tdata[F_VALUE_LO +: BYTE_W] == $past(s_tdata))
        else $error("input byte not passed through");

    // Ignored bytes after a stop carry no entry information.
    a_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == BC_IGNORED |->
            !hc && kind == KIND_REGULAR && size == '0 && stat == ST_OK)
        else $error("ignored byte carries entry data");

    // End block and unsafe path are reported only on a header byte without completion.
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat == ST_END || stat == ST_UNSAFE) |->
            m_tuser == BC_HEADER && !hc)
        else $error("stop status on wrong byte");

    // A completed header never reports a stop status, and the kind code is legal.
    a_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && hc |-> m_tuser == BC_HEADER && kind != 2'd3 &&
            (stat == ST_OK || stat == ST_TRUNCATED))
        else $error("bad completed header word");

endmodule

bind ustar_stream_deframer_unit ustar_checker u_ustar_checker (.*);
